/* rtl/core/rls_pkg.sv */
package rls_pkg;

	localparam int unsigned FIFO_DEPTH = 16;
	localparam int unsigned PTR_W      = $clog2(FIFO_DEPTH);
	localparam int unsigned LVL_W      = $clog2(FIFO_DEPTH + 1);
	localparam int unsigned DATA_W     = 32;
	localparam int unsigned STEP_W     = $clog2(DATA_W);

	localparam logic [DATA_W-1:0] STAT_ALL_ONES = '1;

	typedef enum logic [1:0] {
		CMD_START    = 2'd0,
		CMD_DISCARD  = 2'd1,
		CMD_REGISTER = 2'd2,
		CMD_QUERY    = 2'd3
	} cmd_code_t;

	// controller -> datapath
	typedef struct packed {
		logic load;      // capture the transaction
		logic push;      // write timestamp into the FIFO
		logic drop;      // flag a lost start
		logic pop;       // advance the read side
		logic rd;        // read the oldest entry
		logic mul;       // form reaction time and mean*n
		logic acc;       // form dividend, update min/max
		logic div_step;  // one quotient bit
		logic commit;    // write mean and count
	} dp_ctl_t;

	// datapath -> controller
	typedef struct packed {
		cmd_code_t command;
		logic      full;
		logic      empty;
		logic      div_last;
	} dp_stat_t;

endpackage

/* rtl/core/reaction_latency_statistics_unit.sv */
// Channel  | Handshake            | Signals
// ---------+----------------------+----------------------------------------------
// command  | start & !busy        | command, time_ms
// result   | done (1-cycle pulse) | min_time, max_time, mean_time, sample_count,
//          |                      | start_dropped, reaction_taken
//
// Start, discard and query transactions, like a register on an empty FIFO,
// go from acceptance through an execute state to the report state. A register
// that pops a start passes FIFO read, subtract and 32x32 multiply, 64-bit add,
// 32 steps of the restoring divider for the running mean, commit, report.
// busy stays high until the cycle after done; start is ignored while busy.
// arst_n clears the controller, the FIFO level and pointer and the statistics;
// the FIFO storage itself is not cleared. The receiver cannot stall results.
module reaction_latency_statistics_unit (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	output logic                       busy,
	input  logic [1:0]                 command,
	input  logic [rls_pkg::DATA_W-1:0] time_ms,
	output logic                       done,
	output logic [rls_pkg::DATA_W-1:0] min_time,
	output logic [rls_pkg::DATA_W-1:0] max_time,
	output logic [rls_pkg::DATA_W-1:0] mean_time,
	output logic [rls_pkg::DATA_W-1:0] sample_count,
	output logic                       start_dropped,
	output logic                       reaction_taken
);

	rls_pkg::dp_ctl_t  ctl;
	rls_pkg::dp_stat_t stat;

	// Sequence each transaction; the controller owns busy and the done strobe.
	rls_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.ctl    (ctl),
		.busy   (busy),
		.done   (done)
	);

	// Hold the start FIFO, the statistics and the mean divider. Results come
	// straight from the statistics registers, which are final by the done cycle.
	rls_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.ctl            (ctl),
		.command        (command),
		.time_ms        (time_ms),
		.stat           (stat),
		.min_time       (min_time),
		.max_time       (max_time),
		.mean_time      (mean_time),
		.sample_count   (sample_count),
		.start_dropped  (start_dropped),
		.reaction_taken (reaction_taken)
	);

endmodule

/* rtl/core/rls_ctrl.sv */
module rls_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  rls_pkg::dp_stat_t stat,
	output rls_pkg::dp_ctl_t  ctl,
	output logic              busy,
	output logic              done
);

	typedef enum logic [6:0] {
		ST_IDLE   = 7'b0000001,
		ST_EXEC   = 7'b0000010,
		ST_SUB    = 7'b0000100,
		ST_ACC    = 7'b0001000,
		ST_DIV    = 7'b0010000,
		ST_COMMIT = 7'b0100000,
		ST_REPORT = 7'b1000000
	} state_t;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		ctl     = '0;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					ctl.load = 1'b1;
					state_d  = ST_EXEC;
				end
			end
			ST_EXEC: begin
				state_d = ST_REPORT;
				case (stat.command)
					rls_pkg::CMD_START: begin
						if (stat.full) begin
							ctl.drop = 1'b1;
						end else begin
							ctl.push = 1'b1;
						end
					end
					rls_pkg::CMD_DISCARD: begin
						ctl.pop = !stat.empty;
					end
					rls_pkg::CMD_REGISTER: begin
						if (!stat.empty) begin
							ctl.pop = 1'b1;
							ctl.rd  = 1'b1;
							state_d = ST_SUB;
						end
					end
					default: begin
					end
				endcase
			end
			ST_SUB: begin
				ctl.mul = 1'b1;
				state_d = ST_ACC;
			end
			ST_ACC: begin
				ctl.acc = 1'b1;
				state_d = ST_DIV;
			end
			ST_DIV: begin
				ctl.div_step = 1'b1;
				if (stat.div_last) begin
					state_d = ST_COMMIT;
				end
			end
			ST_COMMIT: begin
				ctl.commit = 1'b1;
				state_d    = ST_REPORT;
			end
			ST_REPORT: begin
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign busy = (state_q != ST_IDLE);
	assign done = (state_q == ST_REPORT);

endmodule

/* rtl/core/rls_dp.sv */
module rls_dp (
	input  logic                         clk,
	input  logic                         arst_n,
	input  rls_pkg::dp_ctl_t             ctl,
	input  logic [1:0]                   command,
	input  logic [rls_pkg::DATA_W-1:0]   time_ms,
	output rls_pkg::dp_stat_t            stat,
	output logic [rls_pkg::DATA_W-1:0]   min_time,
	output logic [rls_pkg::DATA_W-1:0]   max_time,
	output logic [rls_pkg::DATA_W-1:0]   mean_time,
	output logic [rls_pkg::DATA_W-1:0]   sample_count,
	output logic                         start_dropped,
	output logic                         reaction_taken
);

	localparam int unsigned DW = rls_pkg::DATA_W;

	// transaction capture
	rls_pkg::cmd_code_t       cmd_q;
	logic [DW-1:0]            time_q;

	// start FIFO
	logic [DW-1:0]            mem [rls_pkg::FIFO_DEPTH];
	logic [DW-1:0]            rd_data_q;
	logic [rls_pkg::PTR_W-1:0] rd_ptr_q;
	logic [rls_pkg::LVL_W-1:0] level_q;
	logic [rls_pkg::LVL_W:0]   wr_sum;
	logic [rls_pkg::PTR_W-1:0] wr_ptr;
	logic [rls_pkg::PTR_W-1:0] rd_ptr_nxt;

	// statistics
	logic [DW-1:0]            min_q, max_q, mean_q, count_q;
	logic                     dropped_q, taken_q;

	// mean update
	logic [DW-1:0]            t_q;
	logic [2*DW-1:0]          prod_q;
	logic [2*DW-1:0]          prod_c;
	logic [2*DW-1:0]          sum_c;
	logic [DW:0]              rem_q;
	logic [DW:0]              divisor_q;
	logic [DW-1:0]            quo_q;
	logic [DW+1:0]            trial;
	logic [rls_pkg::STEP_W-1:0] step_q;

	assign wr_sum = {1'b0, level_q} + (rls_pkg::LVL_W + 1)'(rd_ptr_q);
	assign wr_ptr = (wr_sum >= (rls_pkg::LVL_W + 1)'(rls_pkg::FIFO_DEPTH))
		? rls_pkg::PTR_W'(wr_sum - (rls_pkg::LVL_W + 1)'(rls_pkg::FIFO_DEPTH))
		: rls_pkg::PTR_W'(wr_sum);
	assign rd_ptr_nxt = (rd_ptr_q == rls_pkg::PTR_W'(rls_pkg::FIFO_DEPTH - 1))
		? '0 : rd_ptr_q + rls_pkg::PTR_W'(1);

	assign prod_c = (2*DW)'(mean_q) * (2*DW)'(count_q);
	assign sum_c  = prod_q + (2*DW)'(t_q);
	assign trial  = {rem_q, quo_q[DW-1]} - {1'b0, divisor_q};

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			cmd_q  <= rls_pkg::cmd_code_t'(command);
			time_q <= time_ms;
		end
		if (ctl.push) begin
			mem[wr_ptr] <= time_q;
		end
		if (ctl.rd) begin
			rd_data_q <= mem[rd_ptr_q];
		end
		if (ctl.mul) begin
			t_q    <= time_q - rd_data_q;
			prod_q <= prod_c;
		end
		if (ctl.acc) begin
			// quotient fits in DW bits, so the high half is already below the divisor
			rem_q     <= {1'b0, sum_c[2*DW-1:DW]};
			quo_q     <= sum_c[DW-1:0];
			divisor_q <= {1'b0, count_q} + (DW+1)'(1);
		end else if (ctl.div_step) begin
			if (!trial[DW+1]) begin
				rem_q <= trial[DW:0];
			end else begin
				rem_q <= {rem_q[DW-1:0], quo_q[DW-1]};
			end
			quo_q <= {quo_q[DW-2:0], !trial[DW+1]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_ptr_q  <= '0;
			level_q   <= '0;
			min_q     <= rls_pkg::STAT_ALL_ONES;
			max_q     <= '0;
			mean_q    <= '0;
			count_q   <= '0;
			dropped_q <= 1'b0;
			taken_q   <= 1'b0;
			step_q    <= '0;
		end else begin
			if (ctl.load) begin
				dropped_q <= 1'b0;
				taken_q   <= 1'b0;
			end
			if (ctl.drop) begin
				dropped_q <= 1'b1;
			end
			if (ctl.push) begin
				level_q <= level_q + rls_pkg::LVL_W'(1);
			end else if (ctl.pop) begin
				level_q  <= level_q - rls_pkg::LVL_W'(1);
				rd_ptr_q <= rd_ptr_nxt;
			end
			if (ctl.acc) begin
				taken_q <= 1'b1;
				step_q  <= '0;
				if (t_q < min_q) begin
					min_q <= t_q;
				end
				if (t_q > max_q) begin
					max_q <= t_q;
				end
			end else if (ctl.div_step) begin
				step_q <= step_q + rls_pkg::STEP_W'(1);
			end
			if (ctl.commit) begin
				mean_q <= quo_q;
				if (count_q != rls_pkg::STAT_ALL_ONES) begin
					count_q <= count_q + DW'(1);
				end
			end
		end
	end

	assign stat.command  = cmd_q;
	assign stat.full     = (level_q == rls_pkg::LVL_W'(rls_pkg::FIFO_DEPTH));
	assign stat.empty    = (level_q == '0);
	assign stat.div_last = (step_q == rls_pkg::STEP_W'(DW - 1));

	assign min_time       = min_q;
	assign max_time       = max_q;
	assign mean_time      = mean_q;
	assign sample_count   = count_q;
	assign start_dropped  = dropped_q;
	assign reaction_taken = taken_q;

endmodule

/* rtl/core/rls_checker.sv */
module rls_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       start,
	input logic                       busy,
	input logic                       done,
	input logic [rls_pkg::DATA_W-1:0] min_time,
	input logic [rls_pkg::DATA_W-1:0] max_time,
	input logic [rls_pkg::DATA_W-1:0] sample_count,
	input logic                       start_dropped,
	input logic                       reaction_taken
);

	// done is a single-cycle pulse
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("done held longer than one cycle");

	// an accepted transaction raises busy
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("busy not raised after acceptance");

	// statistics never move in the cycle after an idle one
	a_idle_stable: assert property (@(posedge clk) disable iff (!arst_n)
		!busy |=> ($stable(sample_count) && $stable(min_time) && $stable(max_time)))
		else $error("statistics changed while idle");

	// a taken reaction leaves min not above max
	a_min_max: assert property (@(posedge clk) disable iff (!arst_n)
		(done && reaction_taken) |-> (min_time <= max_time))
		else $error("min above max after a reaction");

	// one command cannot both drop a start and take a reaction
	a_flags: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !(start_dropped && reaction_taken))
		else $error("dropped and taken flagged together");

endmodule

bind reaction_latency_statistics_unit rls_checker u_rls_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.start          (start),
	.busy           (busy),
	.done           (done),
	.min_time       (min_time),
	.max_time       (max_time),
	.sample_count   (sample_count),
	.start_dropped  (start_dropped),
	.reaction_taken (reaction_taken)
);
